// ===== src/wmo_pkg.sv =====
// ----------------------------------------------------------------------------
// wmo_pkg
// shared widths, constants, table word type and fill helpers of the
// wavetable morph oscillator
// ----------------------------------------------------------------------------
package wmo_pkg;

	// payload field widths
	localparam int PHASE_W     = 17;
	localparam int MORPH_W     = 10;
	localparam int SAMPLE_W    = 16;
	localparam int IN_TDATA_W  = 32;
	localparam int OUT_TDATA_W = 16;

	// default geometry
	localparam int TABLE_SIZE_DEF = 512;
	localparam int FRAC_BITS_DEF  = 8;

	// morph scale, 1.0 = 256
	localparam int MORPH_ONE = 256;
	localparam int MORPH_MAX = 512;
	localparam int WEIGHT_W  = 9;

	localparam int FULL_SCALE = 32767;

	// sine generation, q30 fixed point
	localparam int              Q_SH        = 30;
	localparam longint unsigned Q30_HALF_PI = 64'd1686629713;

	// reciprocal shift for the entry index reduction
	localparam int RECIP_SH = 32;

	localparam logic [15:0] LFSR_SEED = 16'hACE1;

	typedef logic signed [SAMPLE_W-1:0] sample_t;

	// one memory word holds the same entry of all three tables
	typedef struct packed {
		sample_t noise;
		sample_t square;
		sample_t sine;
	} tbl_word_t;

	// fibonacci lfsr, taps 16 14 13 11
	function automatic logic [15:0] lfsr_next(input logic [15:0] s);
		logic fb;
		fb = s[0] ^ s[2] ^ s[3] ^ s[5];
		return {fb, s[15:1]};
	endfunction

	// lfsr state as a sample, most negative code folded in
	function automatic sample_t noise_of(input logic [15:0] s);
		return (s == 16'h8000) ? sample_t'(-FULL_SCALE) : sample_t'(s);
	endfunction

	function automatic sample_t square_of(input sample_t s);
		sample_t r;
		if (s > sample_t'(0)) begin
			r = sample_t'(FULL_SCALE);
		end else if (s < sample_t'(0)) begin
			r = sample_t'(-FULL_SCALE);
		end else begin
			r = sample_t'(0);
		end
		return r;
	endfunction

endpackage

// ===== src/wavetable_morph_oscillator_unit.sv =====
// ----------------------------------------------------------------------------
// wavetable_morph_oscillator_unit
// three-table oscillator: sine, square and noise read with linear
// interpolation, then crossfaded by a morph amount from 0 to 2.0
// ----------------------------------------------------------------------------
//
// channel  dir  tdata fields (low bit up)              tuser  tlast
// s_axis   in   phase[16:0], morph[26:17], pad[31:27]  -      -
// m_axis   out  sample[15:0] (signed q1.15)            -      -
//
// one request per clock while nothing stalls; a request passes through the
// stages s1 to s7 and the output register. the rate is set by the table
// memory, which gives the entry and its neighbor through two read ports in
// the same cycle. after reset the tables are filled one entry a cycle while
// s_axis_tready stays low.
// each stage holds its request when the next one is full and stalled, so
// empty stages close up and new requests enter while a result waits.
//
module wavetable_morph_oscillator_unit #(
	parameter int TABLE_SIZE = wmo_pkg::TABLE_SIZE_DEF,
	parameter int FRAC_BITS  = wmo_pkg::FRAC_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// request side
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	input  logic [wmo_pkg::IN_TDATA_W-1:0]   s_axis_tdata,  // phase, morph, zero pad
	// result side
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	output logic [wmo_pkg::OUT_TDATA_W-1:0]  m_axis_tdata   // sample
);

	// ------------------------------------------------------------------
	// derived widths
	// ------------------------------------------------------------------
	localparam int ADDR_W  = $clog2(TABLE_SIZE);
	localparam int IDX_W   = wmo_pkg::PHASE_W - FRAC_BITS;   // entry index bits of phase
	localparam int FW1     = FRAC_BITS + 1;                   // 0 .. 2^FRAC_BITS
	localparam int PROD_W  = IDX_W + wmo_pkg::RECIP_SH;
	localparam int WIDE_W  = 17;                              // holds TABLE_SIZE itself
	localparam int IW      = wmo_pkg::SAMPLE_W + FRAC_BITS + 1;
	localparam int TW      = IW + wmo_pkg::WEIGHT_W + 1;
	localparam int SHIFT   = FRAC_BITS + 8;
	localparam int RES_W   = TW - SHIFT;
	localparam int MW      = wmo_pkg::MORPH_W;

	localparam logic [WIDE_W-1:0]             TBL_N   = WIDE_W'(TABLE_SIZE);
	localparam logic [ADDR_W-1:0]             LAST_IX = ADDR_W'(TABLE_SIZE - 1);
	localparam logic [wmo_pkg::RECIP_SH-1:0]  RECIP_V =
		wmo_pkg::RECIP_SH'((64'd1 << wmo_pkg::RECIP_SH) / TABLE_SIZE);
	localparam logic [FW1-1:0]                SPAN    = FW1'(1) << FRAC_BITS;
	localparam logic signed [TW-1:0]          RND_HALF = TW'(1) << (SHIFT - 1);
	localparam logic signed [RES_W-1:0]       RES_MAX = RES_W'(wmo_pkg::FULL_SCALE);
	localparam logic signed [RES_W-1:0]       RES_MIN = -RES_MAX;
	localparam logic [MW-1:0]                 Z_ONE   = MW'(wmo_pkg::MORPH_ONE);
	localparam logic [MW-1:0]                 Z_MAX   = MW'(wmo_pkg::MORPH_MAX);

	// ------------------------------------------------------------------
	// sine rom, worked out at elaboration: quarter-wave fold, q30 angle,
	// taylor series to x^15 truncating each step, scaled and rounded
	// ------------------------------------------------------------------
	wmo_pkg::sample_t sine_rom [TABLE_SIZE];

	for (genvar g = 0; g < TABLE_SIZE; g++) begin : g_sine
		localparam longint unsigned M  = 64'(4 * g);
		localparam longint unsigned QD = M / TABLE_SIZE;
		localparam longint unsigned RM = M % TABLE_SIZE;
		localparam longint unsigned P  = ((QD % 2) == 1) ? 64'(TABLE_SIZE) - RM : RM;
		localparam longint unsigned X  = (wmo_pkg::Q30_HALF_PI * P) / TABLE_SIZE;
		localparam longint unsigned X2 = (X * X) >> wmo_pkg::Q_SH;
		localparam longint unsigned T1 = ((X  * X2) >> wmo_pkg::Q_SH) / 6;
		localparam longint unsigned T2 = ((T1 * X2) >> wmo_pkg::Q_SH) / 20;
		localparam longint unsigned T3 = ((T2 * X2) >> wmo_pkg::Q_SH) / 42;
		localparam longint unsigned T4 = ((T3 * X2) >> wmo_pkg::Q_SH) / 72;
		localparam longint unsigned T5 = ((T4 * X2) >> wmo_pkg::Q_SH) / 110;
		localparam longint unsigned T6 = ((T5 * X2) >> wmo_pkg::Q_SH) / 156;
		localparam longint unsigned T7 = ((T6 * X2) >> wmo_pkg::Q_SH) / 210;
		localparam longint ONE_Q = longint'(1) << wmo_pkg::Q_SH;
		localparam longint SUM = longint'(X) - longint'(T1) + longint'(T2) - longint'(T3)
			+ longint'(T4) - longint'(T5) + longint'(T6) - longint'(T7);
		localparam longint SUMC = (SUM < 0) ? longint'(0) : ((SUM > ONE_Q) ? ONE_Q : SUM);
		localparam longint unsigned MAG0 =
			(unsigned'(SUMC) * 64'(wmo_pkg::FULL_SCALE) + (64'd1 << (wmo_pkg::Q_SH - 1)))
			>> wmo_pkg::Q_SH;
		localparam longint unsigned MAG =
			(MAG0 > 64'(wmo_pkg::FULL_SCALE)) ? 64'(wmo_pkg::FULL_SCALE) : MAG0;
		localparam wmo_pkg::sample_t SV =
			(QD >= 2) ? -wmo_pkg::sample_t'(MAG) : wmo_pkg::sample_t'(MAG);

		assign sine_rom[g] = SV;
	end

	// ------------------------------------------------------------------
	// table fill after reset
	// ------------------------------------------------------------------
	logic [ADDR_W-1:0]   fill_idx_q;
	logic                fill_run_q;
	logic [15:0]         lfsr_q;
	logic                wr_vld_q;
	logic                tbl_ready_q;
	logic [ADDR_W-1:0]   wr_addr_q;
	wmo_pkg::sample_t    wr_sine_q;
	wmo_pkg::sample_t    wr_noise_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_idx_q  <= '0;
			fill_run_q  <= 1'b1;
			lfsr_q      <= wmo_pkg::LFSR_SEED;
			wr_vld_q    <= 1'b0;
			tbl_ready_q <= 1'b0;
		end else begin
			wr_vld_q <= fill_run_q;
			if (fill_run_q) begin
				fill_idx_q <= fill_idx_q + ADDR_W'(1);
				lfsr_q     <= wmo_pkg::lfsr_next(lfsr_q);
				if (fill_idx_q == LAST_IX) begin
					fill_run_q <= 1'b0;
				end
			end
			// last entry is being written
			if (wr_vld_q && !fill_run_q) begin
				tbl_ready_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		wr_addr_q  <= fill_idx_q;
		wr_sine_q  <= sine_rom[fill_idx_q];
		wr_noise_q <= wmo_pkg::noise_of(lfsr_q);
	end

	// ------------------------------------------------------------------
	// stage enables: a stage moves when it is empty or the next one moves
	// ------------------------------------------------------------------
	logic en_s1, en_s2, en_s3, en_s4, en_s5, en_s6, en_s7, en_out;
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, out_vld_q;
	logic in_fire;

	assign en_out = !out_vld_q || m_axis_tready;
	assign en_s7  = !vld_s7 || en_out;
	assign en_s6  = !vld_s6 || en_s7;
	assign en_s5  = !vld_s5 || en_s6;
	assign en_s4  = !vld_s4 || en_s5;
	assign en_s3  = !vld_s3 || en_s4;
	assign en_s2  = !vld_s2 || en_s3;
	assign en_s1  = !vld_s1 || en_s2;

	// no request until the tables are filled
	assign s_axis_tready = en_s1 && tbl_ready_q;
	assign in_fire       = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			vld_s3    <= 1'b0;
			vld_s4    <= 1'b0;
			vld_s5    <= 1'b0;
			vld_s6    <= 1'b0;
			vld_s7    <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (en_s1)  vld_s1    <= in_fire;
			if (en_s2)  vld_s2    <= vld_s1;
			if (en_s3)  vld_s3    <= vld_s2;
			if (en_s4)  vld_s4    <= vld_s3;
			if (en_s5)  vld_s5    <= vld_s4;
			if (en_s6)  vld_s6    <= vld_s5;
			if (en_s7)  vld_s7    <= vld_s6;
			if (en_out) out_vld_q <= vld_s7;
		end
	end

	// ------------------------------------------------------------------
	// s1: split phase, saturate morph at 2.0
	// ------------------------------------------------------------------
	logic [wmo_pkg::PHASE_W-1:0] in_phase;
	logic [MW-1:0]               in_morph;
	logic [IDX_W-1:0]            idx_s1;
	logic [FRAC_BITS-1:0]        frac_s1;
	logic [MW-1:0]               z_s1;

	assign in_phase = s_axis_tdata[wmo_pkg::PHASE_W-1:0];
	assign in_morph = s_axis_tdata[wmo_pkg::PHASE_W +: MW];

	always_ff @(posedge clk) begin
		if (en_s1) begin
			idx_s1  <= in_phase[wmo_pkg::PHASE_W-1:FRAC_BITS];
			frac_s1 <= in_phase[FRAC_BITS-1:0];
			z_s1    <= (in_morph > Z_MAX) ? Z_MAX : in_morph;
		end
	end

	// ------------------------------------------------------------------
	// s2: quotient estimate idx / TABLE_SIZE by reciprocal, may be one low
	// ------------------------------------------------------------------
	logic [PROD_W-1:0]    recip_prod;
	logic [IDX_W-1:0]     quot_s2;
	logic [IDX_W-1:0]     idx_s2;
	logic [FRAC_BITS-1:0] frac_s2;
	logic [MW-1:0]        z_s2;

	assign recip_prod = PROD_W'(idx_s1) * PROD_W'(RECIP_V);

	always_ff @(posedge clk) begin
		if (en_s2) begin
			quot_s2 <= IDX_W'(recip_prod >> wmo_pkg::RECIP_SH);
			idx_s2  <= idx_s1;
			frac_s2 <= frac_s1;
			z_s2    <= z_s1;
		end
	end

	// ------------------------------------------------------------------
	// s3: quotient times table size, low bits are enough
	// ------------------------------------------------------------------
	logic [IDX_W-1:0]     qn_s3;
	logic [IDX_W-1:0]     idx_s3;
	logic [FRAC_BITS-1:0] frac_s3;
	logic [MW-1:0]        z_s3;

	always_ff @(posedge clk) begin
		if (en_s3) begin
			qn_s3   <= IDX_W'(quot_s2 * TBL_N);
			idx_s3  <= idx_s2;
			frac_s3 <= frac_s2;
			z_s3    <= z_s2;
		end
	end

	// ------------------------------------------------------------------
	// s4: remainder below twice the size, one correcting subtract
	// ------------------------------------------------------------------
	logic [IDX_W-1:0]     rem;
	logic [WIDE_W-1:0]    rem_x;
	logic [WIDE_W-1:0]    rem_fix;
	logic [ADDR_W-1:0]    a_s4;
	logic [ADDR_W-1:0]    b_s4;
	logic [FRAC_BITS-1:0] frac_s4;
	logic [MW-1:0]        z_s4;

	assign rem     = idx_s3 - qn_s3;
	assign rem_x   = WIDE_W'(rem);
	assign rem_fix = (rem_x >= TBL_N) ? rem_x - TBL_N : rem_x;

	always_ff @(posedge clk) begin
		if (en_s4) begin
			a_s4    <= ADDR_W'(rem_fix);
			frac_s4 <= frac_s3;
			z_s4    <= z_s3;
		end
	end

	// neighbor entry wraps round to entry 0
	assign b_s4 = (a_s4 == LAST_IX) ? '0 : a_s4 + ADDR_W'(1);

	// ------------------------------------------------------------------
	// s5: table memory, one write port for the fill, two read ports
	// ------------------------------------------------------------------
	wmo_pkg::tbl_word_t   tbl_mem [TABLE_SIZE];
	wmo_pkg::tbl_word_t   rd_a_s5;
	wmo_pkg::tbl_word_t   rd_b_s5;
	logic [FRAC_BITS-1:0] frac_s5;
	logic [MW-1:0]        z_s5;

	always_ff @(posedge clk) begin
		if (wr_vld_q) begin
			tbl_mem[wr_addr_q] <= '{noise:  wr_noise_q,
			                        square: wmo_pkg::square_of(wr_sine_q),
			                        sine:   wr_sine_q};
		end
	end

	always_ff @(posedge clk) begin
		if (en_s5) begin
			rd_a_s5 <= tbl_mem[a_s4];
			rd_b_s5 <= tbl_mem[b_s4];
			frac_s5 <= frac_s4;
			z_s5    <= z_s4;
		end
	end

	// ------------------------------------------------------------------
	// s6: pick the two tables of the morph half, interpolate both,
	// split morph into crossfade weights
	// ------------------------------------------------------------------
	logic                    hi_sel;
	wmo_pkg::sample_t        lo_a, lo_b, hi_a, hi_b;
	logic [FW1-1:0]          wf_a, wf_b;
	logic signed [IW-1:0]    lo_a_x, lo_b_x, hi_a_x, hi_b_x, wf_a_x, wf_b_x;
	logic signed [IW-1:0]    i_lo, i_hi;
	logic [wmo_pkg::WEIGHT_W-1:0] w_lo, w_hi;
	logic signed [IW-1:0]    i_lo_s6, i_hi_s6;
	logic [wmo_pkg::WEIGHT_W-1:0] w_lo_s6, w_hi_s6;

	// above 1.0 the fade runs square into noise
	assign hi_sel = z_s5 > Z_ONE;

	assign lo_a = hi_sel ? rd_a_s5.square : rd_a_s5.sine;
	assign lo_b = hi_sel ? rd_b_s5.square : rd_b_s5.sine;
	assign hi_a = hi_sel ? rd_a_s5.noise  : rd_a_s5.square;
	assign hi_b = hi_sel ? rd_b_s5.noise  : rd_b_s5.square;

	assign wf_b = FW1'(frac_s5);
	assign wf_a = SPAN - wf_b;

	assign lo_a_x = IW'(lo_a);
	assign lo_b_x = IW'(lo_b);
	assign hi_a_x = IW'(hi_a);
	assign hi_b_x = IW'(hi_b);
	assign wf_a_x = $signed(IW'(wf_a));
	assign wf_b_x = $signed(IW'(wf_b));

	assign i_lo = lo_a_x * wf_a_x + lo_b_x * wf_b_x;
	assign i_hi = hi_a_x * wf_a_x + hi_b_x * wf_b_x;

	assign w_lo = hi_sel ? wmo_pkg::WEIGHT_W'(Z_MAX - z_s5) : wmo_pkg::WEIGHT_W'(Z_ONE - z_s5);
	assign w_hi = hi_sel ? wmo_pkg::WEIGHT_W'(z_s5 - Z_ONE) : wmo_pkg::WEIGHT_W'(z_s5);

	always_ff @(posedge clk) begin
		if (en_s6) begin
			i_lo_s6 <= i_lo;
			i_hi_s6 <= i_hi;
			w_lo_s6 <= w_lo;
			w_hi_s6 <= w_hi;
		end
	end

	// ------------------------------------------------------------------
	// s7: crossfade products
	// ------------------------------------------------------------------
	logic signed [TW-1:0] i_lo_x, i_hi_x, w_lo_x, w_hi_x;
	logic signed [TW-1:0] p_lo_s7, p_hi_s7;

	assign i_lo_x = TW'(i_lo_s6);
	assign i_hi_x = TW'(i_hi_s6);
	assign w_lo_x = $signed(TW'(w_lo_s6));
	assign w_hi_x = $signed(TW'(w_hi_s6));

	always_ff @(posedge clk) begin
		if (en_s7) begin
			p_lo_s7 <= i_lo_x * w_lo_x;
			p_hi_s7 <= i_hi_x * w_hi_x;
		end
	end

	// ------------------------------------------------------------------
	// output register: sum, round half up, clamp to +-full scale
	// ------------------------------------------------------------------
	logic signed [TW-1:0]    t_sum;
	logic signed [RES_W-1:0] res;
	wmo_pkg::sample_t        sample_nx;
	wmo_pkg::sample_t        out_sample_q;

	assign t_sum = p_lo_s7 + p_hi_s7 + RND_HALF;
	assign res   = RES_W'(t_sum >>> SHIFT);

	always_comb begin
		if (res > RES_MAX) begin
			sample_nx = wmo_pkg::sample_t'(wmo_pkg::FULL_SCALE);
		end else if (res < RES_MIN) begin
			sample_nx = wmo_pkg::sample_t'(-wmo_pkg::FULL_SCALE);
		end else begin
			sample_nx = wmo_pkg::sample_t'(res);
		end
	end

	always_ff @(posedge clk) begin
		if (en_out) begin
			out_sample_q <= sample_nx;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = out_sample_q;

	// ------------------------------------------------------------------
	// checks
	// ------------------------------------------------------------------
`ifndef NO_ASSERTIONS
	// tables stay filled once the fill pass is over
	a_ready_holds: assert property (@(posedge clk) disable iff (!arst_n)
		tbl_ready_q |=> tbl_ready_q)
		else $error("table ready dropped after fill");

	// reduced entry index lies inside the table
	a_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s4 |-> (32'(a_s4) < TABLE_SIZE))
		else $error("entry index past table end");

	// crossfade weights always add up to one
	a_weight_sum: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s6 |-> ((10'(w_lo_s6) + 10'(w_hi_s6)) == Z_ONE))
		else $error("crossfade weights do not sum to 1.0");

	// clamp keeps the most negative code off the output
	a_out_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata != 16'h8000))
		else $error("sample outside full scale");
`endif

endmodule
